/* hdl/text_lexer_with_paragraphs_macros.svh */
// ---------------------------------------------------------------------------
// text_lexer_with_paragraphs_macros.svh
// Assertion macros for the text lexer.
// ---------------------------------------------------------------------------
`ifndef TEXT_LEXER_WITH_PARAGRAPHS_MACROS_SVH
`define TEXT_LEXER_WITH_PARAGRAPHS_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TLP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer assertion failed");

// next-cycle implication
`define TLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer assertion failed");

`else

`define TLP_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define TLP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hdl/tlp_pkg.sv */
// ---------------------------------------------------------------------------
// tlp_pkg
// Types, constants and character classes for the text lexer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlp_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int LINE_BITS   = 16;
   localparam int NUMBER_BITS = 32;
   localparam int KIND_BITS   = 4;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_NEWLINE = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_PARA    = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_EOF     = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_STOP    = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_HYPHEN  = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_COLON   = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_OPEN    = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_CLOSE   = 4'd10;

   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_STOP   = 8'h2E;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_OPEN   = 8'h28;
   localparam logic [7:0] CHAR_CLOSE  = 8'h29;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_AFTER_NL
   } mode_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       at_end;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   token_kind;
      logic [OFFSET_BITS-1:0] begin_offset;
      logic [OFFSET_BITS-1:0] end_offset;
      logic [LINE_BITS-1:0]   line_no;
      logic [LINE_BITS-1:0]   column_no;
      logic [NUMBER_BITS-1:0] number_value;
      logic                   number_overflow;
      logic                   last_of_item;
   } rsp_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
      logic [KIND_BITS-1:0] k;
      unique case (c)
         CHAR_STOP:   k = KIND_STOP;
         CHAR_HYPHEN: k = KIND_HYPHEN;
         CHAR_COLON:  k = KIND_COLON;
         CHAR_OPEN:   k = KIND_OPEN;
         CHAR_CLOSE:  k = KIND_CLOSE;
         default:     k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] offset_inc(input logic [OFFSET_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

endpackage

/* hdl/text_lexer_with_paragraphs.sv */
// Text lexer with paragraph detection. One source byte, or an end marker, is
// taken per transaction, and a new transaction can be taken every clock. Each
// transaction yields zero, one or two tokens, which queue in a four-entry
// result FIFO and leave at one per clock while rsp_stall is low; the input
// stalls only while that FIFO has room for fewer than two tokens. Identifier
// text is not carried; slice it from begin_offset and end_offset. ignore_nl_ff
// is written through the csr_ channel, which is always ready.
// ---------------------------------------------------------------------------
// text_lexer_with_paragraphs
// Streaming byte lexer: words, numbers, punctuation, newlines, paragraphs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_lexer_with_paragraphs_macros.svh"

module text_lexer_with_paragraphs import tlp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LINE_BITS-1:0]   col_ff, col_in;
   logic [OFFSET_BITS-1:0] tok_begin_ff, tok_begin_in;
   logic [LINE_BITS-1:0]   tok_line_ff, tok_line_in;
   logic [LINE_BITS-1:0]   tok_col_ff, tok_col_in;
   logic [OFFSET_BITS-1:0] ws_begin_ff, ws_begin_in;
   logic [OFFSET_BITS-1:0] nl_end_ff, nl_end_in;
   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic                   acc_ovf_ff, acc_ovf_in;
   logic                   ignore_nl_ff;

   rsp_type                fifo_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]    count_ff;

   logic                   req_accept, rsp_accept;
   logic [7:0]             c;
   logic [OFFSET_BITS-1:0] off_next;
   logic [NUMBER_BITS+3:0] acc_wide;
   rsp_type                word_tok, nl_tok, para_tok;
   rsp_type                close_tok, lex_tok, entry0;
   logic                   close_vld, lex_vld, do_lex;
   logic                   push0, push1;
   logic [1:0]             push_n;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = count_ff > CNT_BITS'(FIFO_DEPTH - 2);
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = fifo_ff[rd_ptr_ff];
   assign csr_ready  = 1'b1;

   assign c        = req_data.char_byte;
   assign off_next = offset_inc(offset_ff);
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                     + (NUMBER_BITS + 4)'(c[3:0]);

   assign word_tok = '{
      token_kind:      (mode_ff == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
      begin_offset:    tok_begin_ff,
      end_offset:      offset_ff,
      line_no:         tok_line_ff,
      column_no:       tok_col_ff,
      number_value:    (mode_ff == MODE_IDENT) ? '0 : acc_ff,
      number_overflow: (mode_ff == MODE_IDENT) ? 1'b0 : acc_ovf_ff,
      last_of_item:    1'b0
   };

   assign nl_tok = '{
      token_kind:      KIND_NEWLINE,
      begin_offset:    ws_begin_ff,
      end_offset:      nl_end_ff,
      line_no:         tok_line_ff,
      column_no:       tok_col_ff,
      number_value:    '0,
      number_overflow: 1'b0,
      last_of_item:    1'b0
   };

   assign para_tok = '{
      token_kind:      KIND_PARA,
      begin_offset:    ws_begin_ff,
      end_offset:      off_next,
      line_no:         tok_line_ff,
      column_no:       tok_col_ff,
      number_value:    '0,
      number_overflow: 1'b0,
      last_of_item:    1'b0
   };

   always_comb begin
      mode_in      = mode_ff;
      offset_in    = offset_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      tok_begin_in = tok_begin_ff;
      tok_line_in  = tok_line_ff;
      tok_col_in   = tok_col_ff;
      ws_begin_in  = ws_begin_ff;
      nl_end_in    = nl_end_ff;
      acc_in       = acc_ff;
      acc_ovf_in   = acc_ovf_ff;
      close_vld    = 1'b0;
      close_tok    = word_tok;
      lex_vld      = 1'b0;
      lex_tok      = '{
         token_kind:      punct_kind(c),
         begin_offset:    offset_ff,
         end_offset:      off_next,
         line_no:         line_ff,
         column_no:       col_ff,
         number_value:    '0,
         number_overflow: 1'b0,
         last_of_item:    1'b1
      };
      do_lex       = 1'b0;
      if (req_accept) begin
         if (req_data.at_end) begin
            unique case (mode_ff)
               MODE_IDENT, MODE_NUMBER: begin
                  close_vld = 1'b1;
                  close_tok = word_tok;
               end
               MODE_AFTER_NL: begin
                  close_vld = !ignore_nl_ff;
                  close_tok = nl_tok;
               end
               default: begin
               end
            endcase
            lex_vld                = 1'b1;
            lex_tok.token_kind     = KIND_EOF;
            lex_tok.end_offset     = offset_ff;
            ws_begin_in            = offset_ff;
            mode_in                = MODE_IDLE;
         end else begin
            unique case (mode_ff)
               MODE_IDENT: begin
                  if (!is_alpha(c)) begin
                     close_vld   = 1'b1;
                     close_tok   = word_tok;
                     ws_begin_in = offset_ff;
                     do_lex      = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit(c)) begin
                     if (acc_wide[NUMBER_BITS+3:NUMBER_BITS] != 4'b0) begin
                        acc_in     = '1;
                        acc_ovf_in = 1'b1;
                     end else begin
                        acc_in = acc_wide[NUMBER_BITS-1:0];
                     end
                  end else begin
                     close_vld   = 1'b1;
                     close_tok   = word_tok;
                     ws_begin_in = offset_ff;
                     do_lex      = 1'b1;
                  end
               end
               MODE_AFTER_NL: begin
                  priority if (c == CHAR_SPACE || c == CHAR_TAB) begin
                  end else if (c == CHAR_NL) begin
                     close_vld   = 1'b1;
                     close_tok   = para_tok;
                     ws_begin_in = off_next;
                     mode_in     = MODE_IDLE;
                  end else begin
                     close_tok = nl_tok;
                     if (!ignore_nl_ff) begin
                        close_vld   = 1'b1;
                        ws_begin_in = nl_end_ff;
                     end
                     do_lex = 1'b1;
                  end
               end
               default: begin
                  do_lex = 1'b1;
               end
            endcase
            if (do_lex) begin
               mode_in = MODE_IDLE;
               priority if (c == CHAR_NL) begin
                  tok_line_in = line_ff;
                  tok_col_in  = col_ff;
                  nl_end_in   = off_next;
                  mode_in     = MODE_AFTER_NL;
               end else if (is_space(c)) begin
               end else if (is_alpha(c)) begin
                  tok_begin_in = offset_ff;
                  tok_line_in  = line_ff;
                  tok_col_in   = col_ff;
                  mode_in      = MODE_IDENT;
               end else if (is_digit(c)) begin
                  tok_begin_in = offset_ff;
                  tok_line_in  = line_ff;
                  tok_col_in   = col_ff;
                  acc_in       = NUMBER_BITS'(c[3:0]);
                  acc_ovf_in   = 1'b0;
                  mode_in      = MODE_NUMBER;
               end else begin
                  lex_vld     = 1'b1;
                  ws_begin_in = off_next;
               end
            end
            offset_in = off_next;
            if (c == CHAR_NL) begin
               line_in = line_inc(line_ff);
               col_in  = LINE_BITS'(1);
            end else begin
               col_in = line_inc(col_ff);
            end
         end
      end
      close_tok.last_of_item = !lex_vld;
   end

   assign push0  = close_vld || lex_vld;
   assign push1  = close_vld && lex_vld;
   assign push_n = {push1, push0 && !push1};
   assign entry0 = close_vld ? close_tok : lex_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         offset_ff    <= '0;
         line_ff      <= LINE_BITS'(1);
         col_ff       <= LINE_BITS'(1);
         tok_begin_ff <= '0;
         tok_line_ff  <= LINE_BITS'(1);
         tok_col_ff   <= LINE_BITS'(1);
         ws_begin_ff  <= '0;
         nl_end_ff    <= '0;
         acc_ff       <= '0;
         acc_ovf_ff   <= 1'b0;
         ignore_nl_ff <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         mode_ff      <= mode_in;
         offset_ff    <= offset_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         tok_begin_ff <= tok_begin_in;
         tok_line_ff  <= tok_line_in;
         tok_col_ff   <= tok_col_in;
         ws_begin_ff  <= ws_begin_in;
         nl_end_ff    <= nl_end_in;
         acc_ff       <= acc_in;
         acc_ovf_ff   <= acc_ovf_in;
         if (csr_valid && csr_ready) begin
            ignore_nl_ff <= csr_data;
         end
         wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(push_n);
         if (rsp_accept) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_BITS'(push_n) - CNT_BITS'(rsp_accept);
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         fifo_ff[wr_ptr_ff] <= entry0;
      end
      if (push1) begin
         fifo_ff[wr_ptr_ff + 1'b1] <= lex_tok;
      end
   end

   `TLP_ASSERT_SAME(a_fifo_room, clock, reset, req_accept, count_ff <= CNT_BITS'(FIFO_DEPTH - 2))
   `TLP_ASSERT_NEXT(a_end_idle, clock, reset, req_accept && req_data.at_end, mode_ff == MODE_IDLE)
   `TLP_ASSERT_NEXT(a_end_push, clock, reset, req_accept && req_data.at_end, count_ff != '0)
   `TLP_ASSERT_NEXT(a_end_hold, clock, reset, req_accept && req_data.at_end, offset_ff == $past(offset_ff))

endmodule
